// ===== design/wmf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Window median filter package
// Shared field widths, stream data widths and configuration register indexes.
// ----------------------------------------------------------------------------
package wmf_pkg;

   localparam int PIX_W       = 8;
   localparam int POS_W       = 10;
   localparam int SIZE_W      = 11;
   localparam int RADIUS_W    = 2;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 11;
   localparam int REQ_TDATA_W = 8;
   localparam int RSP_TDATA_W = 32;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_RADIUS = 2'd0,
      CSR_WIDTH  = 2'd1,
      CSR_HEIGHT = 2'd2
   } csr_index_type;

endpackage

// ===== design/window_median_filter_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Window median filter unit
// Streaming square-window median over 8-bit pixels in raster order.
// ----------------------------------------------------------------------------
// Pixels enter on the req_ stream, one transaction per pixel; req_tuser marks
// the first pixel of a frame. For every centre at least the configured radius
// away from each image edge a result leaves on the rsp_ stream carrying the
// median, the centre's row and column, and tlast on the frame's last result.
// Border pixels give no transaction.
// Radius, width and height are written through the csr_ port; the user must
// do so only while the block is idle (not enforced); csr_ready is always high.
// Throughput is one pixel per clock unless the receiver stalls. The rows
// above are kept in one line memory of MAX_WIDTH words, one word per column
// holding all buffered rows, read at acceptance and written back from the
// stage-1 registers, with forwarding when the same column comes round again
// at once. The median uses a rank network over the full window: compare,
// count, select. A result passes the stage registers and the output register.
// When the receiver stalls the whole pipe holds and req_tready drops, so
// nothing is lost. Reset clears the pipe, the position counters and the
// registers (radius 1, 1024 by 1024); the line memory is not cleared.
// ----------------------------------------------------------------------------
module window_median_filter_unit #(
   parameter int MAX_RADIUS = 3,
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [wmf_pkg::REQ_TDATA_W-1:0]        req_tdata,   // [7:0] pixel
   input  logic                                   req_tuser,   // frame_start
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // [7:0] median_value, [17:8] center_row, [27:18] center_col, [31:28] zero
   output logic [wmf_pkg::RSP_TDATA_W-1:0]        rsp_tdata,
   output logic                                   rsp_tlast,   // last_of_frame
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [wmf_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [wmf_pkg::CSR_DATA_W-1:0]         csr_data
);

   localparam int SPAN  = 2 * MAX_RADIUS + 1;
   localparam int LINES = 2 * MAX_RADIUS;
   localparam int NWIN  = SPAN * SPAN;
   localparam int MID   = (NWIN - 1) / 2;
   localparam int CW    = $clog2(MAX_WIDTH);
   localparam int RW    = $clog2(MAX_HEIGHT);
   localparam int WSW   = CW + 1;
   localparam int HSW   = RW + 1;
   localparam int RADW  = $clog2(MAX_RADIUS + 1);
   localparam int SLW   = (LINES > 1) ? $clog2(LINES) : 1;
   localparam int SLCW  = $clog2(2 * LINES);
   localparam int LOW   = $clog2(SPAN);
   localparam int RKW   = $clog2(NWIN);
   localparam int WORDW = LINES * wmf_pkg::PIX_W;
   localparam int CMPW  = 16;
   localparam int PW    = wmf_pkg::PIX_W;
   localparam int QW    = wmf_pkg::POS_W;

   typedef struct packed {
      logic          emit;
      logic          last;
      logic [QW-1:0] row;
      logic [QW-1:0] col;
   } meta_type;

   // configuration
   logic [wmf_pkg::RADIUS_W-1:0] radius_ff;
   logic [wmf_pkg::SIZE_W-1:0]   width_ff;
   logic [wmf_pkg::SIZE_W-1:0]   height_ff;
   logic [RADW-1:0]              rad_eff;
   logic [WSW-1:0]               w_eff;
   logic [HSW-1:0]               h_eff;
   logic [LOW-1:0]               lo;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= wmf_pkg::RADIUS_W'(1);
         width_ff  <= wmf_pkg::SIZE_W'(1024);
         height_ff <= wmf_pkg::SIZE_W'(1024);
      end else if (csr_valid) begin
         case (wmf_pkg::csr_index_type'(csr_index))
            wmf_pkg::CSR_RADIUS: radius_ff <= csr_data[wmf_pkg::RADIUS_W-1:0];
            wmf_pkg::CSR_WIDTH:  width_ff  <= csr_data;
            wmf_pkg::CSR_HEIGHT: height_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      if (CMPW'(radius_ff) > CMPW'(MAX_RADIUS)) rad_eff = RADW'(MAX_RADIUS);
      else rad_eff = RADW'(radius_ff);
      if (width_ff == '0) w_eff = WSW'(1);
      else if (CMPW'(width_ff) > CMPW'(MAX_WIDTH)) w_eff = WSW'(MAX_WIDTH);
      else w_eff = WSW'(width_ff);
      if (height_ff == '0) h_eff = HSW'(1);
      else if (CMPW'(height_ff) > CMPW'(MAX_HEIGHT)) h_eff = HSW'(MAX_HEIGHT);
      else h_eff = HSW'(height_ff);
      lo = LOW'(SPAN - 1) - (LOW'(rad_eff) << 1);
   end

   // pipeline enable: everything moves when the output register can take data
   logic pipe_en;
   logic rsp_valid_ff;
   logic accept;

   assign pipe_en    = !rsp_valid_ff || rsp_tready;
   assign req_tready = pipe_en;
   assign accept     = req_tvalid && pipe_en;

   // position counters
   logic [CW-1:0]  col_ff, col_use, col_in;
   logic [RW-1:0]  row_ff, row_use, row_in;
   logic [SLW-1:0] rm_ff, rm_use, rm_in;
   meta_type       meta0;
   logic [CW:0]    two_r_c;
   logic [RW:0]    two_r_r;
   logic [CW-1:0]  ccol;
   logic [RW-1:0]  crow;

   always_comb begin
      col_use = req_tuser ? '0 : col_ff;
      row_use = req_tuser ? '0 : row_ff;
      rm_use  = req_tuser ? '0 : rm_ff;
      two_r_c = (CW + 1)'(rad_eff) << 1;
      two_r_r = (RW + 1)'(rad_eff) << 1;
      ccol    = col_use - CW'(rad_eff);
      crow    = row_use - RW'(rad_eff);
      meta0.emit = ((RW + 1)'(row_use) >= two_r_r) && ((CW + 1)'(col_use) >= two_r_c);
      meta0.last = (HSW'(row_use) + HSW'(1) == h_eff) && (WSW'(col_use) + WSW'(1) == w_eff);
      meta0.row  = QW'(crow);
      meta0.col  = QW'(ccol);
      col_in = col_use + CW'(1);
      row_in = row_use;
      rm_in  = rm_use;
      if (WSW'(col_use) + WSW'(1) >= w_eff) begin
         col_in = '0;
         if (HSW'(row_use) + HSW'(1) >= h_eff) begin
            row_in = '0;
            rm_in  = '0;
         end else begin
            row_in = row_use + RW'(1);
            rm_in  = (SLCW'(rm_use) + SLCW'(1) == SLCW'(LINES)) ? '0 : rm_use + SLW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
         rm_ff  <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
         rm_ff  <= rm_in;
      end
   end

   // line memory: one word per column holding every buffered row
   logic [WORDW-1:0] line_mem [MAX_WIDTH];
   logic [WORDW-1:0] rd_data_ff;
   logic [WORDW-1:0] fwd_data_ff;
   logic             fwd_ff;
   logic [WORDW-1:0] cur_word;
   logic [WORDW-1:0] wr_word;

   logic           s1_vld_ff;
   logic [CW-1:0]  s1_col_ff;
   logic [SLW-1:0] s1_rm_ff;
   logic [PW-1:0]  s1_pix_ff;
   meta_type       s1_meta_ff;

   always_comb begin
      cur_word = fwd_ff ? fwd_data_ff : rd_data_ff;
      wr_word  = cur_word;
      wr_word[s1_rm_ff * PW +: PW] = s1_pix_ff;
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         rd_data_ff <= line_mem[col_use];
         if (s1_vld_ff) line_mem[s1_col_ff] <= wr_word;
      end
   end

   // a column read while the same column is being written gets the new word
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff <= 1'b0;
      end else if (pipe_en) begin
         fwd_ff <= s1_vld_ff && (s1_col_ff == col_use);
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         fwd_data_ff <= wr_word;
         s1_col_ff   <= col_use;
         s1_rm_ff    <= rm_use;
         s1_pix_ff   <= req_tdata[PW-1:0];
         s1_meta_ff  <= meta0;
      end
   end

   // window registers, oldest row at the top
   logic [PW-1:0]   win_ff [SPAN][SPAN];
   logic [SLCW-1:0] slot_sum [LINES];
   logic [SLW-1:0]  slot [LINES];
   logic            s2_vld_ff;
   meta_type        s2_meta_ff;

   always_comb begin
      for (int k = 0; k < LINES; k++) begin
         slot_sum[k] = SLCW'(s1_rm_ff) + SLCW'(k);
         if (slot_sum[k] >= SLCW'(LINES)) slot[k] = SLW'(slot_sum[k] - SLCW'(LINES));
         else slot[k] = SLW'(slot_sum[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en && s1_vld_ff) begin
         for (int i = 0; i < SPAN; i++) begin
            for (int j = 0; j < SPAN - 1; j++) begin
               win_ff[i][j] <= win_ff[i][j+1];
            end
         end
         for (int k = 0; k < LINES; k++) begin
            win_ff[k][SPAN-1] <= cur_word[slot[k] * PW +: PW];
         end
         win_ff[LINES][SPAN-1] <= s1_pix_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) s2_meta_ff <= s1_meta_ff;
   end

   // padding outside the active window: equal numbers of 0 and 255 keep the
   // middle element unchanged
   logic [PW-1:0] pad_vals [NWIN];

   always_comb begin
      for (int i = 0; i < SPAN; i++) begin
         for (int j = 0; j < SPAN; j++) begin
            if (LOW'(i) < lo) pad_vals[i*SPAN+j] = (i % 2 == 1) ? '1 : '0;
            else if (LOW'(j) < lo) pad_vals[i*SPAN+j] = (j % 2 == 1) ? '1 : '0;
            else pad_vals[i*SPAN+j] = win_ff[i][j];
         end
      end
   end

   // compare stage: le[i][j] for j < i says element j sorts before element i
   logic [NWIN-1:0] le_in [NWIN];
   logic [NWIN-1:0] le_ff [NWIN];
   logic [PW-1:0]   s3_vals_ff [NWIN];
   logic            s3_vld_ff;
   meta_type        s3_meta_ff;

   always_comb begin
      for (int i = 0; i < NWIN; i++) begin
         le_in[i] = '0;
         for (int j = 0; j < i; j++) begin
            le_in[i][j] = pad_vals[j] <= pad_vals[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         le_ff      <= le_in;
         s3_vals_ff <= pad_vals;
         s3_meta_ff <= s2_meta_ff;
      end
   end

   // rank stage
   logic [RKW-1:0] rank_in [NWIN];
   logic [RKW-1:0] rank_ff [NWIN];
   logic [PW-1:0]  s4_vals_ff [NWIN];
   logic           s4_vld_ff;
   meta_type       s4_meta_ff;

   always_comb begin
      for (int i = 0; i < NWIN; i++) begin
         rank_in[i] = '0;
         for (int j = 0; j < NWIN; j++) begin
            if (j < i) rank_in[i] = rank_in[i] + RKW'(le_ff[i][j]);
            else if (j > i) rank_in[i] = rank_in[i] + RKW'(!le_ff[j][i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         rank_ff    <= rank_in;
         s4_vals_ff <= s3_vals_ff;
         s4_meta_ff <= s3_meta_ff;
      end
   end

   // select the element of middle rank; ranks are distinct
   logic [PW-1:0] median_in;
   logic [PW-1:0] median_ff;
   meta_type      out_meta_ff;

   always_comb begin
      median_in = '0;
      for (int i = 0; i < NWIN; i++) begin
         if (rank_ff[i] == RKW'(MID)) median_in = median_in | s4_vals_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         median_ff   <= median_in;
         out_meta_ff <= s4_meta_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff    <= 1'b0;
         s2_vld_ff    <= 1'b0;
         s3_vld_ff    <= 1'b0;
         s4_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         s1_vld_ff    <= accept;
         s2_vld_ff    <= s1_vld_ff;
         s3_vld_ff    <= s2_vld_ff;
         s4_vld_ff    <= s3_vld_ff;
         rsp_valid_ff <= s4_vld_ff && s4_meta_ff.emit;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0, out_meta_ff.col, out_meta_ff.row, median_ff};
   assign rsp_tlast  = out_meta_ff.last;

endmodule
